@@ hw/rtl/cot_pkg.sv @@
// cot_pkg: shared constants for the contiguous-run OR coverage tracker
// no dependencies; used by the channel interfaces and the top level

package cot_pkg;

  // width of one input element or query mask on the channel
  localparam int unsigned ELEM_W    = 12;
  // deepest suffix chain for 12-bit elements
  localparam int unsigned SUF_DEPTH = ELEM_W + 1;
  localparam int unsigned SUF_IDX_W = 4;
  // covered mask counter, saturating
  localparam int unsigned COUNT_W   = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  // generation tag kept in each coverage map entry
  localparam int unsigned EPOCH_W   = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

  // item kinds
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

@@ hw/rtl/cot_if.sv @@
// cot_in_if / cot_out_if: valid/ready channels for items and results
// depends on cot_pkg

interface cot_in_if;
  import cot_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ELEM_W-1:0] value;
  logic              first;

  modport source (output valid, kind, value, first, input ready);
  modport sink   (input valid, kind, value, first, output ready);
endinterface

interface cot_out_if;
  import cot_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 is_covered;
  logic [SUF_IDX_W-1:0] suffix_count;
  logic [COUNT_W-1:0]   covered_count;

  modport source (output valid, is_covered, suffix_count, covered_count, input ready);
  modport sink   (input valid, is_covered, suffix_count, covered_count, output ready);
endinterface

@@ hw/rtl/cot_ram.sv @@
// cot_ram: simple dual-port synchronous ram, one write and one registered read
// no dependencies

module cot_ram #(
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/contiguous_or_coverage_tracker.sv @@
// contiguous_or_coverage_tracker: suffix-OR chain and coverage bitmap of a word
// depends on cot_pkg, cot_in_if / cot_out_if and cot_ram
//
//   channel | dir | transaction payload
//   in_i    | in  | kind, value, first
//   out_o   | out | is_covered, suffix_count, covered_count
//
// a push runs through the accept step, one pass through the suffix ram for the new
//   element and one per entry of the chain before it (at most 13 entries), one drain
//   step and the result step; each chain entry is one read-check-write of the coverage
//   map through its single read port
// a query runs through the accept step, one coverage map read, its tag compare and
//   the result step
// after reset the coverage map is swept, every entry cleared, before any item is taken;
//   the same sweep runs on every 255th word start when the generation tag wraps
// a result waits in the output register; the next item is accepted meanwhile and
//   only its final step stalls until the output register is free

module contiguous_or_coverage_tracker #(
  parameter int unsigned K_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  cot_in_if.sink    in_i,
  cot_out_if.source out_o
);
  import cot_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_QRD,
    ST_QCHK,
    ST_DONE
  } state_e;

  localparam int unsigned SUF_ADDR_W = SUF_IDX_W + 1;

  state_e               state_q, state_d;
  logic                 item_q, item_d;
  logic                 kind_q, kind_d;
  logic [K_BITS-1:0]    x_q, x_d;
  logic [SUF_IDX_W-1:0] old_len_q, old_len_d;
  logic [SUF_IDX_W-1:0] suf_len_q, suf_len_d;
  logic [SUF_IDX_W-1:0] j_q, j_d;
  logic [SUF_IDX_W-1:0] n_q, n_d;
  logic [K_BITS-1:0]    last_q, last_d;
  logic                 bank_q, bank_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [COUNT_W-1:0]   cnt_q, cnt_d;
  logic [K_BITS-1:0]    clr_q, clr_d;
  logic                 mark_pend_q, mark_pend_d;
  logic [K_BITS-1:0]    mark_addr_q, mark_addr_d;
  logic                 hit_q, hit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_cov_q, out_cov_d;
  logic [SUF_IDX_W-1:0] out_suf_q, out_suf_d;
  logic [COUNT_W-1:0]   out_cnt_q, out_cnt_d;

  logic [ELEM_W+K_BITS-1:0] value_wide;
  logic [K_BITS-1:0]        elem_k;
  logic [K_BITS-1:0]        cand;
  logic                     emit;
  logic                     out_free;
  logic                     mark_new;

  logic                  suf_we;
  logic [SUF_ADDR_W-1:0] suf_waddr, suf_raddr;
  logic [K_BITS-1:0]     suf_rdata;

  logic                  cov_we;
  logic [K_BITS-1:0]     cov_waddr, cov_raddr;
  logic [EPOCH_W-1:0]    cov_wdata, cov_rdata;

  // element or mask cut or zero-extended to K_BITS
  assign value_wide = {{K_BITS{1'b0}}, in_i.value};
  assign elem_k     = value_wide[K_BITS-1:0];

  // next chain candidate: the new element itself, then each old suffix ORed with it
  assign cand = (j_q == '0) ? x_q : (suf_rdata | x_q);
  assign emit = (state_q == ST_RUN) && ((j_q == '0) || (cand != last_q)) &&
                (n_q < SUF_IDX_W'(SUF_DEPTH));

  // mark stage: the entry read last cycle is new to this word
  assign mark_new = mark_pend_q && (cov_rdata != epoch_q);

  assign out_free = !out_valid_q || out_o.ready;

  // suffix ram: old chain in bank_q, new chain built in the other bank
  assign suf_we    = emit;
  assign suf_waddr = {~bank_q, n_q};
  assign suf_raddr = {bank_q, j_q};

  cot_ram #(
    .ADDR_W (SUF_ADDR_W),
    .DATA_W (K_BITS)
  ) u_suf_ram (
    .clk_i   (clk_i),
    .we_i    (suf_we),
    .waddr_i (suf_waddr),
    .wdata_i (cand),
    .raddr_i (suf_raddr),
    .rdata_o (suf_rdata)
  );

  // coverage map: entry holds the generation tag of the word that marked it
  always_comb begin
    if (state_q == ST_CLEAR) begin
      cov_we    = 1'b1;
      cov_waddr = clr_q;
      cov_wdata = EPOCH_NONE;
    end else begin
      cov_we    = mark_new;
      cov_waddr = mark_addr_q;
      cov_wdata = epoch_q;
    end
  end

  assign cov_raddr = (state_q == ST_RUN) ? cand : x_q;

  cot_ram #(
    .ADDR_W (K_BITS),
    .DATA_W (EPOCH_W)
  ) u_cov_ram (
    .clk_i   (clk_i),
    .we_i    (cov_we),
    .waddr_i (cov_waddr),
    .wdata_i (cov_wdata),
    .raddr_i (cov_raddr),
    .rdata_o (cov_rdata)
  );

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    kind_d      = kind_q;
    x_d         = x_q;
    old_len_d   = old_len_q;
    suf_len_d   = suf_len_q;
    j_d         = j_q;
    n_d         = n_q;
    last_d      = last_q;
    bank_d      = bank_q;
    epoch_d     = epoch_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    mark_pend_d = 1'b0;
    mark_addr_d = mark_addr_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_cov_d   = out_cov_q;
    out_suf_d   = out_suf_q;
    out_cnt_d   = out_cnt_q;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // count a newly covered nonzero mask
    if (mark_new && (mark_addr_q != '0) && (cnt_q != COUNT_MAX)) begin
      cnt_d = cnt_q + COUNT_W'(1);
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + K_BITS'(1);
        if (clr_q == {K_BITS{1'b1}}) begin
          epoch_d = EPOCH_FIRST;
          item_d  = 1'b0;
          if (!item_q) begin
            state_d = ST_IDLE;
          end else if (kind_q == KIND_PUSH) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_QRD;
          end
        end
      end

      ST_IDLE: begin
        if (in_i.valid) begin
          kind_d    = in_i.kind;
          x_d       = elem_k;
          j_d       = '0;
          n_d       = '0;
          hit_d     = 1'b0;
          old_len_d = in_i.first ? '0 : suf_len_q;
          if (in_i.kind == KIND_PUSH) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_QRD;
          end
          // word start: drop the chain, the count and every mark
          if (in_i.first) begin
            suf_len_d = '0;
            cnt_d     = '0;
            if (epoch_q == EPOCH_LAST) begin
              item_d  = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end
        end
      end

      ST_RUN: begin
        if (emit) begin
          n_d         = n_q + SUF_IDX_W'(1);
          last_d      = cand;
          mark_pend_d = 1'b1;
          mark_addr_d = cand;
        end
        if (j_q == old_len_q) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + SUF_IDX_W'(1);
        end
      end

      // last mark settles before the result is formed
      ST_DRAIN: begin
        state_d = ST_DONE;
      end

      ST_QRD: begin
        state_d = ST_QCHK;
      end

      ST_QCHK: begin
        hit_d   = (cov_rdata == epoch_q);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cov_d   = hit_q;
          out_cnt_d   = cnt_q;
          if (kind_q == KIND_PUSH) begin
            out_suf_d = n_q;
            suf_len_d = n_q;
            bank_d    = ~bank_q;
          end else begin
            out_suf_d = suf_len_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      item_q      <= 1'b0;
      suf_len_q   <= '0;
      bank_q      <= 1'b0;
      epoch_q     <= EPOCH_FIRST;
      cnt_q       <= '0;
      clr_q       <= '0;
      mark_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      suf_len_q   <= suf_len_d;
      bank_q      <= bank_d;
      epoch_q     <= epoch_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      mark_pend_q <= mark_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    x_q         <= x_d;
    old_len_q   <= old_len_d;
    j_q         <= j_d;
    n_q         <= n_d;
    last_q      <= last_d;
    mark_addr_q <= mark_addr_d;
    hit_q       <= hit_d;
    out_cov_q   <= out_cov_d;
    out_suf_q   <= out_suf_d;
    out_cnt_q   <= out_cnt_d;
  end

  // channel ports
  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.is_covered    = out_cov_q;
  assign out_o.suffix_count  = out_suf_q;
  assign out_o.covered_count = out_cnt_q;

  // chain never outgrows its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    suf_len_q <= SUF_IDX_W'(SUF_DEPTH))
    else $error("suffix chain length beyond capacity");

  // entries written to the new chain never outrun the candidates seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (n_q <= j_q))
    else $error("more chain entries than candidates");

  // the live tag never equals the cleared tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != EPOCH_NONE)
    else $error("generation tag collides with cleared entries");

  // a word start on the last tag sweeps the map before the item proceeds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.first && (epoch_q == EPOCH_LAST)) |=>
    (state_q == ST_CLEAR))
    else $error("tag wrap without map sweep");

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for contiguous_or_coverage_tracker, with directed words,
// random words and a run of word starts; results are checked against a local model
// depends on cot_pkg, cot_in_if / cot_out_if and the tracker rtl

module tb;
  import cot_pkg::*;

  localparam int unsigned K_BITS        = 12;
  localparam int unsigned MAP_SIZE      = 1 << K_BITS;
  localparam logic [ELEM_W-1:0] ELEM_MASK = ELEM_W'(MAP_SIZE - 1);
  localparam int unsigned RANDOM_ITEMS  = 130;
  localparam int unsigned RESTART_ITEMS = 260;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned IDLE_LIMIT    = 20000;

  typedef struct packed {
    logic                 is_covered;
    logic [SUF_IDX_W-1:0] suffix_count;
    logic [COUNT_W-1:0]   covered_count;
  } cover_result_t;

  // suffix-or chain, coverage bitmap and the results still owed by the block
  class or_cover_model;
    logic [ELEM_W-1:0] chain [SUF_DEPTH];
    int unsigned       chain_len;
    bit                covered [MAP_SIZE];
    int unsigned       mask_total;
    logic [ELEM_W-1:0] marked_q [$];
    cover_result_t     owed_q [$];
    int unsigned       fail_count, checked, hits, deepest;
    int unsigned       pushes, queries, word_starts;

    function new();
      clear_word();
    endfunction

    function void clear_word();
      foreach (chain[i]) chain[i] = '0;
      foreach (covered[i]) covered[i] = 1'b0;
      chain_len  = 0;
      mask_total = 0;
      marked_q.delete();
    endfunction

    function void mark_mask(logic [ELEM_W-1:0] m);
      if (!covered[m]) begin
        covered[m] = 1'b1;
        marked_q.insert(marked_q.size(), m);
        if (m != '0 && mask_total < COUNT_MAX) mask_total++;
      end
    endfunction

    // new chain: the element itself, then every older suffix or-ed with it, deduplicated
    function void push_elem(logic [ELEM_W-1:0] x);
      logic [ELEM_W-1:0] grown [SUF_DEPTH];
      logic [ELEM_W-1:0] v;
      int unsigned       n;
      bit                dup;
      grown[0] = x;
      n = 1;
      for (int unsigned i = 0; i < chain_len; i++) begin
        v = chain[i] | x;
        dup = 1'b0;
        for (int unsigned j = 0; j < n; j++) if (grown[j] == v) dup = 1'b1;
        if (!dup && n < SUF_DEPTH) begin
          grown[n] = v;
          n++;
        end
      end
      foreach (chain[i]) chain[i] = '0;
      for (int unsigned i = 0; i < n; i++) begin
        chain[i] = grown[i];
        mark_mask(grown[i]);
      end
      chain_len = n;
      if (n > deepest) deepest = n;
    endfunction

    function void note_item(logic kind, logic [ELEM_W-1:0] value, logic first);
      cover_result_t     r;
      logic [ELEM_W-1:0] v;
      v = value & ELEM_MASK;
      if (first) begin
        clear_word();
        word_starts++;
      end
      r.is_covered = 1'b0;
      if (kind == KIND_PUSH) begin
        push_elem(v);
        pushes++;
      end else begin
        r.is_covered = covered[v];
        queries++;
        if (covered[v]) hits++;
      end
      r.suffix_count  = SUF_IDX_W'(chain_len);
      r.covered_count = COUNT_W'(mask_total);
      owed_q.insert(owed_q.size(), r);
    endfunction

    function void check_result(cover_result_t got);
      cover_result_t want;
      if (owed_q.size() == 0) begin
        $error("result transaction arrived with none outstanding");
        fail_count++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got.is_covered !== want.is_covered) begin
        $error("is_covered: expected %0d, got %0d", want.is_covered, got.is_covered);
        fail_count++;
      end
      if (got.suffix_count !== want.suffix_count) begin
        $error("suffix_count: expected %0d, got %0d", want.suffix_count, got.suffix_count);
        fail_count++;
      end
      if (got.covered_count !== want.covered_count) begin
        $error("covered_count: expected %0d, got %0d", want.covered_count,
               got.covered_count);
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cot_in_if  in_if ();
  cot_out_if out_if ();

  contiguous_or_coverage_tracker #(
    .K_BITS(K_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  or_cover_model sb;
  bit            hold_req;
  int unsigned   holds_done;
  int unsigned   burst_left;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // offer one transaction, in bursts with random gaps, and note it once taken
  task automatic send_item(input logic kind, input logic [ELEM_W-1:0] value,
                           input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.value <= value;
    in_if.first <= first;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_item(kind, value, first);
  endtask

  // push values: single bits and zero grow long chains, sparse and dense fill the map
  function automatic logic [ELEM_W-1:0] pick_push(int unsigned style);
    case (style)
      0: pick_push = ($urandom_range(0, 9) == 0) ? '0 : ELEM_W'(1) << $urandom_range(0, 11);
      1: pick_push = ELEM_W'($urandom & $urandom & $urandom);
      default: pick_push = ELEM_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // queries: mostly masks already marked in this word, some near misses and noise
  function automatic logic [ELEM_W-1:0] pick_query();
    int unsigned       roll;
    logic [ELEM_W-1:0] m;
    roll = $urandom_range(0, 9);
    if (sb.marked_q.size() == 0 || roll >= 8) begin
      pick_query = ($urandom_range(0, 4) == 0) ? '0 : ELEM_W'($urandom_range(0, 4095));
    end else begin
      m = sb.marked_q[$urandom_range(0, sb.marked_q.size() - 1)];
      if (roll >= 6) m = m ^ (ELEM_W'(1) << $urandom_range(0, 11));
      pick_query = m;
    end
  endfunction

  // receiver: stretches of steady, patchy or blocked ready, plus one long hold-off
  initial begin
    int unsigned stretch;
    int unsigned mode;
    stretch = 0;
    mode    = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(4, 60);
      end
      stretch--;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= 1'b0;
      endcase
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_result('{out_if.is_covered, out_if.suffix_count, out_if.covered_count});
    end
  end

  // watchdog: too long without any transaction on either side
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) idle = 0;
      else idle++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, sb.owed_q.size());
    $display("contiguous_or_coverage_tracker test failed");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned wlen;
    int unsigned style;
    logic        start;
    logic        is_query;
    sb         = new();
    hold_req   = 1'b0;
    holds_done = 0;
    burst_left = 0;
    in_if.valid <= 1'b0;
    in_if.kind  <= KIND_PUSH;
    in_if.value <= '0;
    in_if.first <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed: one-hot climb, then zero on top to reach the deepest chain
    for (int unsigned b = 0; b < ELEM_W; b++) send_item(KIND_PUSH, ELEM_W'(1) << b, b == 0);
    send_item(KIND_PUSH, '0, 1'b0);
    send_item(KIND_QUERY, '0, 1'b0);
    send_item(KIND_QUERY, '1, 1'b0);
    send_item(KIND_QUERY, ELEM_W'(5), 1'b0);
    send_item(KIND_QUERY, ELEM_W'(12'h800), 1'b0);
    // query that starts a word sees an empty map
    send_item(KIND_QUERY, '0, 1'b1);
    send_item(KIND_PUSH, '1, 1'b1);
    send_item(KIND_PUSH, '1, 1'b0);
    send_item(KIND_QUERY, '1, 1'b0);
    send_item(KIND_PUSH, '0, 1'b0);
    send_item(KIND_QUERY, '0, 1'b0);
    send_item(KIND_QUERY, '1, 1'b1);

    // random words with the occasional stray word start
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wlen  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
      style = $urandom_range(0, 2);
      for (int unsigned j = 0; j < wlen; j++) begin
        if (sent == RANDOM_ITEMS / 3) hold_req = 1'b1;
        start    = (j == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 39) == 0);
        is_query = ($urandom_range(0, 9) < 3);
        if (is_query) send_item(KIND_QUERY, pick_query(), start);
        else send_item(KIND_PUSH, pick_push(style), start);
        sent++;
      end
    end

    // run of single-item words, enough to wrap the map generation tag
    for (int unsigned i = 0; i < RESTART_ITEMS; i++) begin
      send_item(1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? '0 : ELEM_W'($urandom_range(0, 4095)), 1'b1);
    end
    in_if.valid <= 1'b0;

    // drain, then a quiet spell to catch stray results
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d pushes and %0d queries (%0d hits) over %0d word starts",
             sb.pushes, sb.queries, sb.hits, sb.word_starts);
    $display("deepest suffix chain %0d, %0d long receiver hold-offs, %0d results checked",
             sb.deepest, holds_done, sb.checked);
    if (sb.fail_count == 0) begin
      $display("contiguous_or_coverage_tracker test passed");
    end else begin
      $display("contiguous_or_coverage_tracker test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cot_pkg.sv
hw/rtl/cot_if.sv
hw/rtl/cot_ram.sv
hw/rtl/contiguous_or_coverage_tracker.sv
bench/tb.sv
